[rtl/core/psnr_pkg.sv]
// ----------------------------------------------------------------------------
// PSNR engine package
// Shared types and constants of the PSNR engine.
// ----------------------------------------------------------------------------
package psnr_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int LOG_FRAC = 28;
    localparam logic [25:0] DB_PER_LOG2_Q24 = 26'd50504453;
    localparam logic [47:0] PEAK_RESET = 48'd16711680;

    typedef enum logic [2:0] {
        ELEM_U8  = 3'd0,
        ELEM_S8  = 3'd1,
        ELEM_U16 = 3'd2,
        ELEM_S16 = 3'd3,
        ELEM_U32 = 3'd4,
        ELEM_S32 = 3'd5
    } elem_t;

    localparam logic CFG_ELEM_TYPE = 1'b0;
    localparam logic CFG_PEAK      = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_LOG_LOAD,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_LOG_DONE,
        ST_SCALE,
        ST_ROUND,
        ST_OUT
    } state_t;

endpackage

[rtl/core/image_psnr_engine_top.sv]
// ----------------------------------------------------------------------------
// PSNR engine top level
// Accumulates squared sample differences and computes PSNR per image.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  s_axis  | in        | s_axis_tvalid/tready  | tdata {b,a}, tlast last_sample
//  m_axis  | out       | m_axis_tvalid/tready  | tdata {sat,sum,psnr}
//  cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// An ordinary pair passes through accept, one shared 33x33 multiply, and
// the saturating accumulate. The pair marked last then runs up to three
// logarithms on the same multiplier. Each is a load, a leading-one search
// by one-bit shifts, 28 squaring steps and a combine step. Scale, round
// and hand-off follow.
// Reset clears the sum, count, flag and registers to their defaults.
// A finished result moves into an output register, so the next image can
// start while it waits on m_axis_tready. A second result waits in ST_OUT,
// with no new item accepted, until that register is free.
// ----------------------------------------------------------------------------
module image_psnr_engine_top
    import psnr_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sample_a [31:0], sample_b [63:32]
    input  logic [63:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // psnr_db [31:0], sum_squared [95:32], sum_saturated [96], zeros above
    output logic [103:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data
);

    state_t state_reg, state_next;

    logic [2:0]            elem_reg;
    logic [47:0]           peak_reg;
    logic [63:0]           sum_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  ovf_reg;
    logic                  last_reg;
    logic [32:0]           diff_reg;
    logic [65:0]           prod_reg;

    // Output register that holds a finished result until it is taken.
    logic                  out_valid_reg;
    logic [96:0]           out_data_reg;
    logic                  out_free;

    // log unit working registers
    logic [1:0]            lsel_reg;   // 0 peak, 1 count, 2 sum
    logic [63:0]           lx_reg;
    logic [5:0]            le_reg;
    logic [32:0]           lm_reg;
    logic [4:0]            lstep_reg;
    logic [33:0]           lr_reg;     // log2 in Q6.28
    logic signed [41:0]    v_reg;      // V in Q.28
    logic signed [67:0]    p_reg;
    logic [31:0]           psnr_reg;

    logic signed [33:0] a_dec, b_dec, diff_s;
    logic [32:0] mul_a, mul_b;
    logic [65:0] mul_p;
    logic [64:0] sum_ext;

    function automatic logic signed [33:0] decode(input logic [2:0] t, input logic [31:0] r);
        case (t)
            ELEM_S8:  decode = {{26{r[7]}}, r[7:0]};
            ELEM_U16: decode = {18'd0, r[15:0]};
            ELEM_S16: decode = {{18{r[15]}}, r[15:0]};
            ELEM_U32: decode = {2'd0, r};
            ELEM_S32: decode = {{2{r[31]}}, r};
            default:  decode = {26'd0, r[7:0]};
        endcase
    endfunction

    assign a_dec  = decode(elem_reg, s_axis_tdata[31:0]);
    assign b_dec  = decode(elem_reg, s_axis_tdata[63:32]);
    assign diff_s = (a_dec >= b_dec) ? a_dec - b_dec : b_dec - a_dec;

    // The one shared multiplier: difference square or log mantissa square.
    always_comb
    begin
        if (state_reg == ST_MUL) begin
            mul_a = diff_reg;
            mul_b = diff_reg;
        end else begin
            mul_a = lm_reg;
            mul_b = lm_reg;
        end
        mul_p = mul_a * mul_b;
    end

    assign sum_ext = {1'b0, sum_reg} + {1'b0, prod_reg[63:0]};

    // The output register can take a result when empty or being emptied.
    assign out_free = !out_valid_reg || m_axis_tready;

    logic signed [41:0] lr_ext;
    assign lr_ext = {8'd0, lr_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_axis_tvalid) state_next = ST_MUL;
            ST_MUL:      state_next = ST_ACC;
            ST_ACC:      state_next = last_reg ? ST_LOG_LOAD : ST_IDLE;
            ST_LOG_LOAD: state_next = ST_LOG_NORM;
            ST_LOG_NORM: if (lx_reg[63] || le_reg == 6'd0) state_next = ST_LOG_SQ;
            ST_LOG_SQ:   if (lstep_reg == 5'd0) state_next = ST_LOG_DONE;
            ST_LOG_DONE:
                if (lsel_reg == 2'd2 || (lsel_reg == 2'd1 && sum_reg == 64'd0))
                    state_next = ST_SCALE;
                else
                    state_next = ST_LOG_LOAD;
            ST_SCALE:    state_next = ST_ROUND;
            ST_ROUND:    state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        cfg_ready     = (state_reg == ST_IDLE);
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = {7'd0, out_data_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            elem_reg      <= ELEM_U8;
            peak_reg      <= PEAK_RESET;
            sum_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready && cfg_index[1] == 1'b0) begin
                if (cfg_index[0] == CFG_ELEM_TYPE)
                    elem_reg <= cfg_data[2:0];
                else
                    peak_reg <= cfg_data;
            end
            if (state_reg == ST_ACC) begin
                if (sum_ext[64]) begin
                    sum_reg <= '1;
                    ovf_reg <= 1'b1;
                end else begin
                    sum_reg <= sum_ext[63:0];
                end
                if (count_reg != {COUNT_BITS{1'b1}})
                    count_reg <= count_reg + 1'b1;
            end
            if (state_reg == ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {ovf_reg, sum_reg, psnr_reg};
                sum_reg       <= '0;
                count_reg     <= '0;
                ovf_reg       <= 1'b0;
            end else if (out_valid_reg && m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers; the log unit shares the multiplier above.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid) begin
                    diff_reg <= diff_s[32:0];
                    last_reg <= s_axis_tlast;
                    lsel_reg <= 2'd0;
                end
            ST_MUL: prod_reg <= mul_p;
            ST_LOG_LOAD:
            begin
                unique case (lsel_reg)
                    2'd0:    lx_reg <= {16'd0, peak_reg};
                    2'd1:    lx_reg <= {{(64-COUNT_BITS){1'b0}}, count_reg};
                    default: lx_reg <= sum_reg;
                endcase
                le_reg    <= 6'd63;
                lstep_reg <= 5'(LOG_FRAC - 1);
                lr_reg    <= '0;
            end
            ST_LOG_NORM:
                if (lx_reg[63] || le_reg == 6'd0) begin
                    lm_reg <= {1'b0, lx_reg[63:32]};
                    lr_reg <= {le_reg, 28'd0};
                end else begin
                    lx_reg <= {lx_reg[62:0], 1'b0};
                    le_reg <= le_reg - 6'd1;
                end
            ST_LOG_SQ:
            begin
                if (mul_p[63]) begin
                    lm_reg <= mul_p[64:32];
                    lr_reg <= lr_reg | (34'd1 << lstep_reg);
                end else begin
                    lm_reg <= mul_p[63:31];
                end
                lstep_reg <= lstep_reg - 5'd1;
            end
            ST_LOG_DONE:
            begin
                unique case (lsel_reg)
                    2'd0: v_reg <= (lr_ext <<< 1) - (42'sd32 <<< LOG_FRAC)
                                   + ((sum_reg == 64'd0) ? (42'sd104 <<< LOG_FRAC) : 42'sd0);
                    2'd1: v_reg <= v_reg + ((sum_reg == 64'd0) ? 42'sd0 : lr_ext);
                    default: v_reg <= v_reg - lr_ext;
                endcase
                lsel_reg <= lsel_reg + 2'd1;
            end
            ST_SCALE: p_reg <= v_reg * $signed({1'b0, DB_PER_LOG2_Q24});
            ST_ROUND:
            begin
                logic [67:0] mag;
                logic [67:0] rnd;
                mag = p_reg[67] ? 68'(-p_reg) : 68'(p_reg);
                rnd = (mag + (68'd1 << 35)) >> 36;
                if (peak_reg == 48'd0)
                    psnr_reg <= 32'h8000_0000;
                else if (p_reg[67])
                    psnr_reg <= (rnd > 68'h8000_0000) ? 32'h8000_0000 : 32'(-rnd);
                else
                    psnr_reg <= (rnd > 68'h7FFF_FFFF) ? 32'h7FFF_FFFF : rnd[31:0];
            end
            default: ;
        endcase
    end

    // The log mantissa stays normalized below 2.0 during the squaring steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOG_SQ |-> lm_reg[32] == 1'b0)
        else $error("log mantissa out of range");

    // A result is presented only after it leaves the output state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_OUT)
        else $error("result without output state");

    // The sum is clear after a result moves to the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && out_free |=> sum_reg == 64'd0 && !ovf_reg)
        else $error("sum not cleared");

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

[bench/tb_image_psnr_engine_top.sv]
// ----------------------------------------------------------------------------
// PSNR engine regression bench
// Streams sample pairs into the PSNR engine under every element type and
// several peak settings, predicts each image result in the bench, and checks
// every result field by field under varied source and sink idling.
// ----------------------------------------------------------------------------
module tb_image_psnr_engine_top;
    import psnr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes of the configuration channel.
    localparam logic [1:0] REG_ELEM_TYPE = 2'd0;
    localparam logic [1:0] REG_PEAK      = 2'd1;
    localparam logic [1:0] REG_SPARE2    = 2'd2;
    localparam logic [1:0] REG_SPARE3    = 2'd3;

    // Idle phases: percentage of cycles in which the source or sink holds off.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_HIGH = 60;
    localparam int IDLE_LOW  = 12;

    localparam logic [63:0] SUM_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        saturated;
        logic [63:0] sum_sq;
        logic [31:0] db;
    } image_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [47:0]  cfg_data;

    image_psnr_engine_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Shadow copy of the engine's registers and accumulator state.
    logic [2:0]    mdl_elem;
    logic [47:0]   mdl_peak;
    logic [63:0]   mdl_sum;
    logic [31:0]   mdl_count;
    logic          mdl_ovf;

    image_result_t pending_images[$];
    int            errors;
    int            items_sent;
    int            images_checked;
    int            src_idle_pct;
    int            snk_idle_pct;

    // Widens a raw sample to a signed value according to the element type.
    function automatic longint widen_sample(logic [31:0] raw);
        case (mdl_elem)
            ELEM_S8:  widen_sample = longint'($signed(raw[7:0]));
            ELEM_U16: widen_sample = longint'({48'd0, raw[15:0]});
            ELEM_S16: widen_sample = longint'($signed(raw[15:0]));
            ELEM_U32: widen_sample = longint'({32'd0, raw});
            ELEM_S32: widen_sample = longint'($signed(raw));
            default:  widen_sample = longint'({56'd0, raw[7:0]});
        endcase
    endfunction

    // Base-2 logarithm of a nonzero integer in Q.28, by repeated squaring.
    function automatic longint log2_fixed(logic [63:0] x);
        int          e;
        logic [63:0] m;
        logic [127:0] sq;
        longint      r;
        e = 63;
        while (e > 0 && x[e] == 1'b0)
            e--;
        if (e >= 31)
            m = x >> (e - 31);
        else
            m = x << (31 - e);
        r = longint'(e) <<< LOG_FRAC;
        for (int i = LOG_FRAC - 1; i >= 0; i--)
        begin
            sq = m * m;
            m = sq[94:31];
            if (m >= 64'h1_0000_0000)
            begin
                r += longint'(1) <<< i;
                m = m >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] psnr_q16(logic [63:0] sum, logic [31:0] count);
        longint      v;
        longint      p;
        logic [63:0] mag;
        logic        neg;
        if (mdl_peak == 48'd0)
            return 32'h8000_0000;
        v = 2 * (log2_fixed({16'd0, mdl_peak}) - (longint'(16) <<< LOG_FRAC));
        if (sum == 64'd0)
            v += longint'(104) <<< LOG_FRAC;
        else
            v += log2_fixed({32'd0, count}) - log2_fixed(sum);
        p = v * longint'(DB_PER_LOG2_Q24);
        neg = p < 0;
        mag = neg ? 64'd0 - 64'(p) : 64'(p);
        mag = (mag + (64'd1 << 35)) >> 36;
        if (neg)
        begin
            if (mag > (64'd1 << 31))
                return 32'h8000_0000;
            return 32'(64'd0 - mag);
        end
        if (mag > 64'h7FFF_FFFF)
            return 32'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    // Folds one accepted pair into the shadow state and queues a result on last.
    task automatic accumulate_pair(logic [31:0] a, logic [31:0] b, logic last);
        longint      wa;
        longint      wb;
        logic [63:0] diff;
        logic [63:0] sq;
        image_result_t res;
        wa = widen_sample(a);
        wb = widen_sample(b);
        diff = (wa >= wb) ? 64'(wa - wb) : 64'(wb - wa);
        sq = diff * diff;
        if (sq > SUM_MAX - mdl_sum)
        begin
            mdl_sum = SUM_MAX;
            mdl_ovf = 1'b1;
        end
        else
            mdl_sum = mdl_sum + sq;
        if (mdl_count < CNT_MAX)
            mdl_count++;
        if (last)
        begin
            res.db = psnr_q16(mdl_sum, mdl_count);
            res.sum_sq = mdl_sum;
            res.saturated = mdl_ovf;
            pending_images.push_back(res);
            mdl_sum = 64'd0;
            mdl_count = 32'd0;
            mdl_ovf = 1'b0;
        end
    endtask

    // Sends one sample pair, idling beforehand at the current source rate.
    // Valid stays high after the accept; the next call updates or drops it, a drain drops it.
    task automatic send_pair(logic [31:0] a, logic [31:0] b, logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        accumulate_pair(a, b, last);
        items_sent++;
    endtask

    // Waits until every queued result has come back, then lets the engine settle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_images.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [47:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (index == REG_ELEM_TYPE)
            mdl_elem = value[2:0];
        else if (index == REG_PEAK)
            mdl_peak = value;
    endtask

    // Sink side: random back-pressure, and a check of each accepted result.
    always @(posedge clk)
    begin
        image_result_t got;
        image_result_t exp;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[96:0];
            if (pending_images.size() == 0)
            begin
                $error("result with no image pending: %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                exp = pending_images.pop_front();
                images_checked++;
                if (got.db !== exp.db)
                begin
                    $error("psnr_db expected %h actual %h", exp.db, got.db);
                    errors++;
                end
                if (got.sum_sq !== exp.sum_sq)
                begin
                    $error("sum_squared expected %h actual %h", exp.sum_sq, got.sum_sq);
                    errors++;
                end
                if (got.saturated !== exp.saturated)
                begin
                    $error("sum_saturated expected %b actual %b",
                           exp.saturated, got.saturated);
                    errors++;
                end
                if (m_axis_tdata[103:97] !== 7'd0)
                begin
                    $error("pad bits expected 0 actual %h", m_axis_tdata[103:97]);
                    errors++;
                end
            end
        end
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Directed extremes: every type with full-scale and zero differences.
    task automatic test_directed();
        for (int t = 0; t < 8; t++)
        begin
            write_reg(REG_ELEM_TYPE, 48'(t));
            send_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
            send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
            send_pair(32'h1234_5678, 32'h1234_5678, 1'b1);
        end
        // An overflowing sum: u32 full-scale squares add past 2^64.
        write_reg(REG_ELEM_TYPE, 48'(ELEM_U32));
        for (int i = 0; i < 4; i++)
            send_pair(32'h0, 32'hFFFF_FFFF, i == 3);
        // A zero peak, the extreme peak, unused register indexes, then a peak of one.
        write_reg(REG_PEAK, 48'd0);
        send_pair(32'd1, 32'd9, 1'b1);
        write_reg(REG_PEAK, 48'hFFFF_FFFF_FFFF);
        send_pair(32'd0, 32'd0, 1'b1);
        send_pair(32'd0, 32'd1, 1'b1);
        write_reg(REG_SPARE2, 48'h5555_5555_5555);
        write_reg(REG_SPARE3, 48'hAAAA_AAAA_AAAA);
        write_reg(REG_PEAK, 48'd1);
        send_pair(32'hFFFF_FFFF, 32'h0, 1'b1);
    endtask

    // Random images of short length with random content under one setting.
    task automatic test_random_images(int pairs);
        int n;
        n = 0;
        while (n < pairs)
        begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
            for (int i = 0; i < len; i++)
            begin
                logic [31:0] a;
                logic [31:0] b;
                a = $urandom();
                b = ($urandom_range(3) == 0) ? a ^ (32'd1 << $urandom_range(31)) : $urandom();
                send_pair(a, b, i == len - 1);
                n++;
            end
        end
    endtask

    task automatic test_idle_phase(int src, int snk, int pairs);
        src_idle_pct = src;
        snk_idle_pct = snk;
        write_reg(REG_ELEM_TYPE, 48'($urandom_range(7)));
        write_reg(REG_PEAK, ($urandom_range(1) == 0) ? {$urandom(), 16'd0} : 48'($urandom())
                            | {16'($urandom()), 32'd0});
        test_random_images(pairs);
    endtask

    initial
    begin
        errors = 0;
        items_sent = 0;
        images_checked = 0;
        src_idle_pct = IDLE_NONE;
        snk_idle_pct = IDLE_NONE;
        mdl_elem = 3'd0;
        mdl_peak = PEAK_RESET;
        mdl_sum = 64'd0;
        mdl_count = 32'd0;
        mdl_ovf = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 64'd0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 2'd0;
        cfg_data = 48'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset defaults are exercised before any register write.
        send_pair(32'd10, 32'd3, 1'b1);
        test_directed();
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: test_idle_phase(IDLE_NONE, IDLE_NONE, 130);
                1: test_idle_phase(IDLE_HIGH, IDLE_NONE, 130);
                2: test_idle_phase(IDLE_NONE, IDLE_HIGH, 130);
                default: test_idle_phase(IDLE_LOW, IDLE_LOW, 130);
            endcase
        end

        drain_results();
        $display("Sent %0d pairs and checked %0d image results", items_sent, images_checked);
        $display("across all element types, peak extremes and four idle mixes.");
        if (errors == 0)
            $display("image_psnr_engine_top regression: pass");
        else
            $display("image_psnr_engine_top regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("image_psnr_engine_top regression: fail");
        $finish;
    end

endmodule
